// File: design/essr_pkg.sv
// ----------------------------------------------------------------------------
// essr_pkg
// Types and constants shared by the speed step regulator modules.
// ----------------------------------------------------------------------------
package essr_pkg;

  // Divider datapath
  localparam int unsigned DivW  = 32;
  localparam int unsigned StepW = $clog2(DivW + 1);

  // Field widths
  localparam int unsigned SpeedW = 13;  // measured speed never exceeds 2^32 / 1e6
  localparam int unsigned FreqW  = 24;  // 10000000 / period fits 24 bits
  localparam int unsigned SlotsW = 28;  // slots_per_turn * 1000000

  // Arithmetic constants
  localparam logic [FreqW-1:0]  FreqNum      = 24'd10000000;
  localparam logic [11:0]       PiMilli      = 12'd3142;
  localparam logic [19:0]       SpeedScale   = 20'd1000000;
  localparam logic [3:0]        LimitScale   = 4'd10;
  localparam logic [15:0]       DutyFull     = 16'd1000;
  localparam logic [StepW-1:0]  FreqSteps    = StepW'(FreqW);
  localparam logic [StepW-1:0]  SpeedSteps   = StepW'(DivW);

  // Ramp constants
  localparam logic [7:0]  HoldMax      = 8'd255;
  localparam logic [7:0]  UpSlowHold   = 8'd3;
  localparam logic [7:0]  DownSlowHold = 8'd5;
  localparam logic [7:0]  FastHold     = 8'd15;
  localparam logic [12:0] FastStep     = 13'd10;

  // Item modes
  localparam logic [2:0] ModeTick    = 3'd0;
  localparam logic [2:0] ModeUp      = 3'd1;
  localparam logic [2:0] ModeDown    = 3'd2;
  localparam logic [2:0] ModeRelease = 3'd3;
  localparam logic [2:0] ModeOff     = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CfgMaxSpeed   = 3'd0;
  localparam logic [2:0] CfgMinSpeed   = 3'd1;
  localparam logic [2:0] CfgDutyMin    = 3'd2;
  localparam logic [2:0] CfgDutyMax    = 3'd3;
  localparam logic [2:0] CfgWheelDiam  = 3'd4;
  localparam logic [2:0] CfgSlots      = 3'd5;
  localparam logic [2:0] CfgCurrentThr = 3'd6;

  typedef enum logic [3:0] {
    StIdle,
    StTick,
    StDiv1,
    StMul1,
    StMul2,
    StDiv2,
    StUpdate,
    StExec,
    StDone
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DivW-1:0]  dividend;
    logic [DivW-1:0]  divisor;
    logic [StepW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic up;
    logic down;
    logic release_hold;
  } setpt_cmd_t;

endpackage

// File: design/essr_div.sv
// ----------------------------------------------------------------------------
// essr_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module essr_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  essr_pkg::div_req_t req_i,
  output essr_pkg::div_rsp_t rsp_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [essr_pkg::StepW-1:0]   cnt_q, cnt_d;
  logic [essr_pkg::DivW-1:0]    rem_q, rem_d;
  logic [essr_pkg::DivW-1:0]    quo_q, quo_d;
  logic [essr_pkg::DivW-1:0]    dvs_q, dvs_d;
  logic [essr_pkg::DivW:0]      trial;
  logic [essr_pkg::DivW:0]      diff;
  logic                         fits;

  always_comb begin
    trial  = {rem_q, quo_q[essr_pkg::DivW-1]};
    diff   = trial - {1'b0, dvs_q};
    fits   = (trial >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // shift in next dividend bit, subtract if it fits
      rem_d = fits ? diff[essr_pkg::DivW-1:0] : trial[essr_pkg::DivW-1:0];
      quo_d = {quo_q[essr_pkg::DivW-2:0], fits};
      cnt_d = cnt_q - essr_pkg::StepW'(1);
      if (cnt_q == essr_pkg::StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: design/essr_setpt.sv
// ----------------------------------------------------------------------------
// essr_setpt
// Speed setpoint ramp with hold-count acceleration.
// ----------------------------------------------------------------------------
module essr_setpt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  essr_pkg::setpt_cmd_t cmd_i,
  input  logic [11:0]          max_speed_i,
  input  logic [11:0]          min_speed_i,
  output logic [11:0]          setpoint_o
);

  logic [11:0] sp_q, sp_d;
  logic [7:0]  hold_q, hold_d;
  logic [12:0] sp_w, mx_w, mn_w;
  logic [7:0]  hold_inc;

  always_comb begin
    sp_w     = {1'b0, sp_q};
    mx_w     = {1'b0, max_speed_i};
    mn_w     = {1'b0, min_speed_i};
    hold_inc = (hold_q == essr_pkg::HoldMax) ? hold_q : hold_q + 8'd1;
    sp_d     = sp_q;
    hold_d   = hold_q;
    if (cmd_i.up) begin
      if (hold_q == 8'd0 && sp_w < mx_w) begin
        sp_d   = sp_q + 12'd1;
        hold_d = hold_inc;
      end else if (hold_q inside {[8'd1 : essr_pkg::UpSlowHold]}) begin
        hold_d = hold_inc;
      end else if (hold_q > essr_pkg::UpSlowHold && hold_q <= essr_pkg::FastHold
                   && sp_w < mx_w) begin
        sp_d   = sp_q + 12'd1;
        hold_d = hold_inc;
      end else if (hold_q > essr_pkg::FastHold && sp_w + essr_pkg::FastStep < mx_w) begin
        sp_d   = 12'(sp_w + essr_pkg::FastStep);
        hold_d = hold_inc;
      end else if (hold_q > essr_pkg::FastHold && sp_w < mx_w) begin
        sp_d   = sp_q + 12'd1;
        hold_d = hold_inc;
      end
    end else if (cmd_i.down) begin
      if (hold_q == 8'd0 && sp_w > mn_w) begin
        sp_d   = sp_q - 12'd1;
        hold_d = hold_inc;
      end else if (hold_q inside {[8'd1 : essr_pkg::DownSlowHold]}) begin
        hold_d = hold_inc;
      end else if (hold_q > essr_pkg::DownSlowHold && hold_q <= essr_pkg::FastHold
                   && sp_w > mn_w) begin
        sp_d   = sp_q - 12'd1;
        hold_d = hold_inc;
      end else if (hold_q > essr_pkg::FastHold && sp_w > mn_w + essr_pkg::FastStep) begin
        sp_d   = 12'(sp_w - essr_pkg::FastStep);
        hold_d = hold_inc;
      end else if (hold_q > essr_pkg::FastHold && sp_w > mn_w) begin
        sp_d   = sp_q - 12'd1;
        hold_d = hold_inc;
      end
    end else if (cmd_i.release_hold) begin
      hold_d = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q   <= 12'd0;
      hold_q <= 8'd0;
    end else begin
      sp_q   <= sp_d;
      hold_q <= hold_d;
    end
  end

  assign setpoint_o = sp_q;

endmodule

// File: design/encoder_speed_step_regulator_core.sv
// ----------------------------------------------------------------------------
// encoder_speed_step_regulator_core
// DC motor speed regulator: encoder speed measure, PWM compare, duty stepping.
// ----------------------------------------------------------------------------
// A measuring control tick passes twice through the shared bit-serial divider
//   (24 + 32 steps) on its way from input beat to result.
// One item is in flight at a time; the input is ready again the cycle after
//   the result is parked in the output register.
// Reset: all regulator state clears, configuration takes its default values.
// ----------------------------------------------------------------------------
module encoder_speed_step_regulator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [15:0] capture_period_i,
  input  logic [15:0] motor_current_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] pwm_compare_o,
  output logic [9:0]  duty_now_o,
  output logic [15:0] measured_speed_o,
  output logic [11:0] target_speed_o,
  output logic        running_o
);

  // --------------------------------------------------------------------------
  // Compare load: d = 1000 - duty (16-bit wrap); inside the duty window the
  // compare becomes 2d-1, at d == 0 it becomes 0, otherwise it holds.
  // --------------------------------------------------------------------------
  function automatic logic [15:0] load_compare(input logic [9:0]  d_in,
                                               input logic [15:0] cur,
                                               input logic [9:0]  dmin,
                                               input logic [9:0]  dmax);
    logic [15:0] d;
    logic [15:0] res;
    d   = essr_pkg::DutyFull - {6'd0, d_in};
    res = cur;
    if (d > {6'd0, dmin} && d <= {6'd0, dmax}) begin
      res = {d[14:0], 1'b0} - 16'd1;
    end else if (d == 16'd0) begin
      res = 16'd0;
    end
    return res;
  endfunction

  // configuration registers
  logic [11:0] max_speed_q, min_speed_q;
  logic [9:0]  duty_min_q, duty_max_q;
  logic [7:0]  wheel_diam_q, slots_q;
  logic [15:0] current_thr_q;

  // sequencer and latched item
  essr_pkg::state_e state_q, state_d;
  logic [2:0]  mode_q, mode_d;
  logic [15:0] period_q, period_d;
  logic [15:0] current_q, current_d;

  // regulator state
  logic [9:0]                   duty_q, duty_d;
  logic [essr_pkg::SpeedW-1:0]  speed_q, speed_d;
  logic                         en_q, en_d;
  logic                         run_q, run_d;
  logic [15:0]                  cmp_q, cmp_d;

  // measurement intermediates
  logic [essr_pkg::FreqW-1:0]   freq_q, freq_d;
  logic [essr_pkg::DivW-1:0]    prod_q, prod_d;
  logic [essr_pkg::SlotsW-1:0]  dvs_q, dvs_d;

  // output register
  logic                         out_valid_q, out_valid_d;
  logic [15:0]                  out_cmp_q;
  logic [9:0]                   out_duty_q;
  logic [essr_pkg::SpeedW-1:0]  out_speed_q;
  logic [11:0]                  out_sp_q;
  logic                         out_run_q;
  logic                         out_load;

  essr_pkg::div_req_t   div_req;
  essr_pkg::div_rsp_t   div_rsp;
  essr_pkg::setpt_cmd_t setpt_cmd;
  logic [11:0]          setpoint;

  logic                 accept;
  logic                 en_tick;
  logic                 meas_go;
  logic [15:0]          speed_limit;
  logic [essr_pkg::SpeedW-1:0] sp_w;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == essr_pkg::StIdle);
  assign accept      = in_valid_i && in_ready_o;

  // Measuring latches on once the current crosses the threshold; the divide
  // chain only runs with a nonzero period and a nonzero slot count.
  assign en_tick     = en_q || (current_q > current_thr_q);
  assign meas_go     = en_tick && (period_q != 16'd0) && (slots_q != 8'd0);
  assign speed_limit = {4'd0, max_speed_q} * {12'd0, essr_pkg::LimitScale};
  assign out_load    = (state_q == essr_pkg::StDone) && (!out_valid_q || out_ready_i);
  assign sp_w        = {1'b0, setpoint};

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q   <= 12'd100;
      min_speed_q   <= 12'd0;
      duty_min_q    <= 10'd0;
      duty_max_q    <= 10'd1000;
      wheel_diam_q  <= 8'd10;
      slots_q       <= 8'd20;
      current_thr_q <= 16'd300;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        essr_pkg::CfgMaxSpeed:   max_speed_q   <= cfg_data_i[11:0];
        essr_pkg::CfgMinSpeed:   min_speed_q   <= cfg_data_i[11:0];
        essr_pkg::CfgDutyMin:    duty_min_q    <= cfg_data_i[9:0];
        essr_pkg::CfgDutyMax:    duty_max_q    <= cfg_data_i[9:0];
        essr_pkg::CfgWheelDiam:  wheel_diam_q  <= cfg_data_i[7:0];
        essr_pkg::CfgSlots:      slots_q       <= cfg_data_i[7:0];
        essr_pkg::CfgCurrentThr: current_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      essr_pkg::StIdle: begin
        if (accept) begin
          state_d = (mode_i == essr_pkg::ModeTick) ? essr_pkg::StTick : essr_pkg::StExec;
        end
      end
      essr_pkg::StTick:   state_d = meas_go ? essr_pkg::StDiv1 : essr_pkg::StUpdate;
      essr_pkg::StDiv1:   if (div_rsp.done) state_d = essr_pkg::StMul1;
      essr_pkg::StMul1:   state_d = essr_pkg::StMul2;
      essr_pkg::StMul2:   state_d = essr_pkg::StDiv2;
      essr_pkg::StDiv2:   if (div_rsp.done) state_d = essr_pkg::StUpdate;
      essr_pkg::StUpdate: state_d = essr_pkg::StDone;
      essr_pkg::StExec:   state_d = essr_pkg::StDone;
      essr_pkg::StDone:   if (out_load) state_d = essr_pkg::StIdle;
      default:            state_d = essr_pkg::StIdle;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and unit commands per state
  // --------------------------------------------------------------------------
  always_comb begin
    mode_d    = mode_q;
    period_d  = period_q;
    current_d = current_q;
    duty_d    = duty_q;
    speed_d   = speed_q;
    en_d      = en_q;
    run_d     = run_q;
    cmp_d     = cmp_q;
    freq_d    = freq_q;
    prod_d    = prod_q;
    dvs_d     = dvs_q;
    div_req   = '0;
    setpt_cmd = '0;
    case (state_q)
      essr_pkg::StIdle: begin
        if (accept) begin
          mode_d    = mode_i;
          period_d  = capture_period_i;
          current_d = motor_current_i;
        end
      end
      essr_pkg::StTick: begin
        // first tick after off: start running and drop the old speed
        if (!run_q) begin
          cmp_d   = load_compare(10'd0, cmp_q, duty_min_q, duty_max_q);
          run_d   = 1'b1;
          speed_d = '0;
        end
        en_d = en_tick;
        if (meas_go) begin
          // 10000000 / period; dividend left-aligned so only 24 steps run
          div_req.start    = 1'b1;
          div_req.dividend = {essr_pkg::FreqNum, 8'd0};
          div_req.divisor  = {16'd0, period_q};
          div_req.steps    = essr_pkg::FreqSteps;
        end
      end
      essr_pkg::StDiv1: begin
        if (div_rsp.done) begin
          freq_d = div_rsp.quotient[essr_pkg::FreqW-1:0];
        end
      end
      essr_pkg::StMul1: begin
        // product wraps at 32 bits
        prod_d = {8'd0, freq_q} * {20'd0, essr_pkg::PiMilli};
        dvs_d  = {20'd0, slots_q} * {8'd0, essr_pkg::SpeedScale};
      end
      essr_pkg::StMul2: begin
        // both nested divisions fold into one divide by slots * 1e6
        div_req.start    = 1'b1;
        div_req.dividend = prod_q * {24'd0, wheel_diam_q};
        div_req.divisor  = {4'd0, dvs_q};
        div_req.steps    = essr_pkg::SpeedSteps;
      end
      essr_pkg::StDiv2: begin
        // drop an over-limit reading
        if (div_rsp.done && div_rsp.quotient <= {16'd0, speed_limit}) begin
          speed_d = div_rsp.quotient[essr_pkg::SpeedW-1:0];
        end
      end
      essr_pkg::StUpdate: begin
        cmp_d = load_compare(duty_q, cmp_q, duty_min_q, duty_max_q);
        if (speed_q < sp_w && ({1'b0, duty_q} + 11'd3) < {1'b0, duty_max_q}) begin
          duty_d = duty_q + 10'd3;
        end else if (speed_q <= sp_w && duty_q < duty_max_q) begin
          duty_d = duty_q + 10'd1;
        end else if (speed_q > sp_w && {1'b0, duty_q} > ({1'b0, duty_min_q} + 11'd2)) begin
          duty_d = duty_q - 10'd2;
        end else if (duty_q == 10'd0 || duty_q > duty_max_q) begin
          speed_d = '0;
          duty_d  = 10'd0;
        end
      end
      essr_pkg::StExec: begin
        case (mode_q)
          essr_pkg::ModeUp:      setpt_cmd.up           = 1'b1;
          essr_pkg::ModeDown:    setpt_cmd.down         = 1'b1;
          essr_pkg::ModeRelease: setpt_cmd.release_hold = 1'b1;
          essr_pkg::ModeOff: begin
            // switch off: setpoint and hold count survive
            speed_d = '0;
            en_d    = 1'b0;
            duty_d  = 10'd0;
            cmp_d   = load_compare(10'd0, cmp_q, duty_min_q, duty_max_q);
            run_d   = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // result beat: park the state snapshot, hold until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= essr_pkg::StIdle;
      duty_q      <= 10'd0;
      speed_q     <= '0;
      en_q        <= 1'b0;
      run_q       <= 1'b0;
      cmp_q       <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      duty_q      <= duty_d;
      speed_q     <= speed_d;
      en_q        <= en_d;
      run_q       <= run_d;
      cmp_q       <= cmp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    period_q  <= period_d;
    current_q <= current_d;
    freq_q    <= freq_d;
    prod_q    <= prod_d;
    dvs_q     <= dvs_d;
    if (out_load) begin
      out_cmp_q   <= cmp_q;
      out_duty_q  <= duty_q;
      out_speed_q <= speed_q;
      out_sp_q    <= setpoint;
      out_run_q   <= run_q;
    end
  end

  // --------------------------------------------------------------------------
  // Shared divider and setpoint ramp
  // --------------------------------------------------------------------------
  essr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  essr_setpt u_setpt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (setpt_cmd),
    .max_speed_i (max_speed_q),
    .min_speed_i (min_speed_q),
    .setpoint_o  (setpoint)
  );

  assign out_valid_o      = out_valid_q;
  assign pwm_compare_o    = out_cmp_q;
  assign duty_now_o       = out_duty_q;
  assign measured_speed_o = {3'd0, out_speed_q};
  assign target_speed_o   = out_sp_q;
  assign running_o        = out_run_q;

endmodule

// File: design/essr_checker.sv
// ----------------------------------------------------------------------------
// essr_checker
// Port-level checks for the speed step regulator.
// ----------------------------------------------------------------------------
module essr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] pwm_compare_o,
  input logic [9:0]  duty_now_o,
  input logic [15:0] measured_speed_o,
  input logic        running_o
);

  // a stalled result beat holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pwm_compare_o)
                                    && $stable(duty_now_o) && $stable(measured_speed_o))
    else $error("result beat dropped or changed while stalled");

  // one item in flight: input closes right after a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input still ready after accepting a beat");

  // compare is always 2d-1 or zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pwm_compare_o[0] || pwm_compare_o == 16'd0)
    else $error("even nonzero PWM compare");

  // stopped regulator reports no duty and no speed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !running_o |-> duty_now_o == 10'd0 && measured_speed_o == 16'd0)
    else $error("stopped regulator reports duty or speed");

endmodule

bind encoder_speed_step_regulator_core essr_checker u_essr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .pwm_compare_o    (pwm_compare_o),
  .duty_now_o       (duty_now_o),
  .measured_speed_o (measured_speed_o),
  .running_o        (running_o)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the encoder speed step regulator. A scoreboard model
// predicts every report from the input beats and the register settings, and a
// monitor compares each result beat field by field, under random stalls on
// both channels and across several register settings.
// ----------------------------------------------------------------------------
module testbench;

  // Unused item modes: the block only reports its state for these
  localparam logic [2:0] ModeSpareLo = 3'd5;
  localparam logic [2:0] ModeSpareHi = 3'd7;

  // Arithmetic of the regulator, as the scoreboard model sees it
  localparam logic [15:0] PerMille  = 16'd1000;
  localparam logic [31:0] TickFreq  = 32'd10000000;
  localparam logic [31:0] PiCoef    = 32'd3142;
  localparam logic [31:0] MegaDiv   = 32'd1000000;
  localparam logic [31:0] SpeedCap  = 32'd10;
  localparam int          HoldSat   = 255;
  localparam int          UpSlowEnd = 3;
  localparam int          DnSlowEnd = 5;
  localparam int          FastFrom  = 15;
  localparam int          CoarseStp = 10;
  localparam int          DutyRise  = 3;
  localparam int          DutyFall  = 2;

  localparam int MaxGap     = 8;
  localparam int MaxReports = 10;
  localparam int Watchdog   = 1000;
  localparam int DrainWait  = 70;

  typedef struct packed {
    logic [15:0] pwm;
    logic [9:0]  duty;
    logic [15:0] speed;
    logic [11:0] target;
    logic        running;
  } report_t;

  typedef struct packed {
    logic [11:0] max_spd;
    logic [11:0] min_spd;
    logic [9:0]  duty_lo;
    logic [9:0]  duty_hi;
    logic [7:0]  wheel;
    logic [7:0]  slots;
    logic [15:0] amp_thr;
  } regulator_cfg_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n = 1'b0;

  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic [2:0]  mode = '0;
  logic [15:0] capture_period = '0;
  logic [15:0] motor_current = '0;
  logic        out_ready = 1'b0;

  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [15:0] pwm_compare_o;
  logic [9:0]  duty_now_o;
  logic [15:0] measured_speed_o;
  logic [11:0] target_speed_o;
  logic        running_o;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  encoder_speed_step_regulator_core i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode),
    .capture_period_i (capture_period),
    .motor_current_i  (motor_current),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .pwm_compare_o    (pwm_compare_o),
    .duty_now_o       (duty_now_o),
    .measured_speed_o (measured_speed_o),
    .target_speed_o   (target_speed_o),
    .running_o        (running_o)
  );

  // --------------------------------------------------------------------------
  // Scoreboard model: registers at their reset values, state cleared
  // --------------------------------------------------------------------------
  logic [11:0] lim_max = 12'd100;
  logic [11:0] lim_min = 12'd0;
  logic [9:0]  duty_lo = 10'd0;
  logic [9:0]  duty_hi = 10'd1000;
  logic [7:0]  wheel_d = 8'd10;
  logic [7:0]  slots_n = 8'd20;
  logic [15:0] amp_thr = 16'd300;

  logic [11:0] setpt = '0;
  logic [7:0]  hold_cnt = '0;
  logic [9:0]  duty_pm = '0;
  logic [31:0] speed_acc = '0;
  logic        meas_on = 1'b0;
  logic        run_on = 1'b0;
  logic [15:0] compare_val = '0;

  report_t regulator_reports[$];   // reports still owed by the DUT

  bit steady = 1'b0;               // no idling on either side while set
  int beats_in = 0;
  int results_seen = 0;
  int failures = 0;
  int cfg_phases = 0;
  int quiet_cycles = 0;
  int out_hold = 0;
  report_t got, want;

  // Load the compare for a duty: (1000 - duty) wraps at 16 bits.
  function automatic void load_pwm_compare(input logic [9:0] duty_in);
    logic [15:0] d;
    d = PerMille - 16'(duty_in);
    if (d > 16'(duty_lo) && d <= 16'(duty_hi)) compare_val = (d << 1) - 16'd1;
    else if (d == 16'd0) compare_val = '0;
  endfunction

  // Convert the encoder period; the product wraps at 32 bits.
  function automatic void sample_speed(input logic [15:0] period);
    logic [31:0] freq, spd;
    if (period == 16'd0 || slots_n == 8'd0) return;
    freq = TickFreq / 32'(period);
    spd  = freq * PiCoef * 32'(wheel_d);
    spd  = spd / 32'(slots_n) / MegaDiv;
    if (spd <= 32'(lim_max) * SpeedCap) speed_acc = spd;
  endfunction

  function automatic void bump_hold();
    if (int'(hold_cnt) < HoldSat) hold_cnt++;
  endfunction

  function automatic void ramp_up();
    int sp, mx, h;
    sp = int'(setpt);
    mx = int'(lim_max);
    h  = int'(hold_cnt);
    if (h == 0 && sp < mx) begin
      setpt++;
      bump_hold();
    end else if (h > 0 && h <= UpSlowEnd) begin
      bump_hold();
    end else if (h > UpSlowEnd && h <= FastFrom && sp < mx) begin
      bump_hold();
      setpt++;
    end else if (h > FastFrom && sp < mx - CoarseStp) begin
      bump_hold();
      setpt += 12'(CoarseStp);
    end else if (h > FastFrom && sp < mx) begin
      bump_hold();
      setpt++;
    end
  endfunction

  function automatic void ramp_down();
    int sp, mn, h;
    sp = int'(setpt);
    mn = int'(lim_min);
    h  = int'(hold_cnt);
    if (h == 0 && sp > mn) begin
      setpt--;
      bump_hold();
    end else if (h > 0 && h <= DnSlowEnd) begin
      bump_hold();
    end else if (h > DnSlowEnd && h <= FastFrom && sp > mn) begin
      bump_hold();
      setpt--;
    end else if (h > FastFrom && sp > mn + CoarseStp) begin
      bump_hold();
      setpt -= 12'(CoarseStp);
    end else if (h > FastFrom && sp > mn) begin
      bump_hold();
      setpt--;
    end
  endfunction

  function automatic void control_tick(input logic [15:0] period, input logic [15:0] current);
    int d, dmax, dmin;
    if (!run_on) begin
      load_pwm_compare('0);
      run_on = 1'b1;
      speed_acc = '0;
    end
    if (current > amp_thr) meas_on = 1'b1;
    if (meas_on) sample_speed(period);
    // compare follows the duty from before this tick
    load_pwm_compare(duty_pm);
    d    = int'(duty_pm);
    dmax = int'(duty_hi);
    dmin = int'(duty_lo);
    if (speed_acc < 32'(setpt) && d + DutyRise < dmax) begin
      duty_pm = 10'(d + DutyRise);
    end else if (speed_acc <= 32'(setpt) && d < dmax) begin
      duty_pm = 10'(d + 1);
    end else if (speed_acc > 32'(setpt) && d > dmin + DutyFall) begin
      duty_pm = 10'(d - DutyFall);
    end else if (d == 0 || d > dmax) begin
      speed_acc = '0;
      duty_pm = '0;
    end
  endfunction

  // Advance the model by one input beat and return the report it owes.
  function automatic report_t regulate(input logic [2:0] m, input logic [15:0] per,
                                       input logic [15:0] cur);
    case (m)
      essr_pkg::ModeTick:    control_tick(per, cur);
      essr_pkg::ModeUp:      ramp_up();
      essr_pkg::ModeDown:    ramp_down();
      essr_pkg::ModeRelease: hold_cnt = '0;
      essr_pkg::ModeOff: begin
        speed_acc = '0;
        meas_on = 1'b0;
        duty_pm = '0;
        load_pwm_compare('0);
        run_on = 1'b0;
      end
      default: ;
    endcase
    return '{compare_val, duty_pm, speed_acc[15:0], setpt, run_on};
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] val);
    case (idx)
      essr_pkg::CfgMaxSpeed:   lim_max = val[11:0];
      essr_pkg::CfgMinSpeed:   lim_min = val[11:0];
      essr_pkg::CfgDutyMin:    duty_lo = val[9:0];
      essr_pkg::CfgDutyMax:    duty_hi = val[9:0];
      essr_pkg::CfgWheelDiam:  wheel_d = val[7:0];
      essr_pkg::CfgSlots:      slots_n = val[7:0];
      essr_pkg::CfgCurrentThr: amp_thr = val;
      default: ;
    endcase
  endfunction

  function automatic void flag_failure(input string msg);
    failures++;
    if (failures <= MaxReports) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Send one input beat; hold valid and payload until accepted, then predict.
  task automatic send_item(input logic [2:0] m, input logic [15:0] per,
                           input logic [15:0] cur);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    mode           <= m;
    capture_period <= per;
    motor_current  <= cur;
    do @(posedge clk); while (!in_ready_o);
    regulator_reports.push_back(regulate(m, per, cur));
    beats_in++;
  endtask

  // Drop valid and wait until every owed report has been checked.
  task automatic settle();
    in_valid <= 1'b0;
    while (regulator_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    apply_reg(idx, val);
  endtask

  // Rewrite all registers back to back while the block is idle.
  task automatic program_regulator(input regulator_cfg_t c);
    settle();
    write_reg(essr_pkg::CfgMaxSpeed, 16'(c.max_spd));
    write_reg(essr_pkg::CfgMinSpeed, 16'(c.min_spd));
    write_reg(essr_pkg::CfgDutyMin, 16'(c.duty_lo));
    write_reg(essr_pkg::CfgDutyMax, 16'(c.duty_hi));
    write_reg(essr_pkg::CfgWheelDiam, 16'(c.wheel));
    write_reg(essr_pkg::CfgSlots, 16'(c.slots));
    write_reg(essr_pkg::CfgCurrentThr, c.amp_thr);
    cfg_valid <= 1'b0;
    @(posedge clk);
    cfg_phases++;
  endtask

  function automatic regulator_cfg_t random_cfg();
    regulator_cfg_t c;
    c.max_spd = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 12))
                                            : 12'($urandom_range(20, 4095));
    c.min_spd = 12'($urandom_range(0, int'(c.max_spd)));
    c.duty_lo = 10'($urandom_range(0, 200));
    c.duty_hi = 10'($urandom_range(int'(c.duty_lo), 1000));
    c.wheel   = 8'($urandom_range(1, 255));
    c.slots   = 8'($urandom_range(1, 255));
    c.amp_thr = 16'($urandom_range(0, 3000));
    return c;
  endfunction

  // Mostly realistic encoder periods, with zero and full-range ones mixed in.
  function automatic logic [15:0] pick_period();
    case ($urandom_range(0, 7))
      0:       return '0;
      1, 2:    return 16'($urandom_range(1, 60));
      3, 4, 5: return 16'($urandom_range(200, 20000));
      default: return 16'($urandom);
    endcase
  endfunction

  // Three in four ticks carry a current above the threshold.
  function automatic logic [15:0] pick_current();
    if ($urandom_range(0, 3) == 0 || amp_thr == 16'hFFFF) return 16'($urandom);
    return 16'($urandom_range(int'(amp_thr) + 1, 65535));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset values: unused modes, start-up tick, threshold edge, zero period,
  // period extremes, release, off and restart.
  task automatic test_first_items();
    send_item(ModeSpareLo, 16'hFFFF, 16'hFFFF);
    send_item(ModeSpareHi, '0, '0);
    send_item(essr_pkg::ModeTick, 16'd0, 16'd300);      // starts running, current at threshold
    send_item(essr_pkg::ModeTick, 16'd500, 16'd300);    // measuring still off
    send_item(essr_pkg::ModeTick, 16'd0, 16'd301);      // measuring on, zero period skips
    send_item(essr_pkg::ModeTick, 16'd1, 16'hFFFF);     // shortest period, product wraps
    send_item(essr_pkg::ModeTick, 16'hFFFF, 16'd0);
    send_item(essr_pkg::ModeTick, 16'd500, 16'd0);
    send_item(essr_pkg::ModeRelease, 16'd77, 16'd99);
    send_item(essr_pkg::ModeOff, 16'd1234, 16'd4321);
    send_item(essr_pkg::ModeTick, 16'd500, 16'd0);      // restart after off
  endtask

  // Walk the up ramp through its slow, single-step and coarse stages.
  task automatic test_hold_ramp();
    repeat (17) send_item(essr_pkg::ModeUp, 16'($urandom), 16'($urandom));
    send_item(essr_pkg::ModeRelease, 16'($urandom), 16'($urandom));
    repeat (2) send_item(essr_pkg::ModeDown, 16'($urandom), 16'($urandom));
  endtask

  // Hold the up key long enough for the hold counter to saturate.
  task automatic test_long_hold();
    repeat (262) send_item(essr_pkg::ModeUp, 16'($urandom), 16'($urandom));
    send_item(essr_pkg::ModeRelease, 16'($urandom), 16'($urandom));
    repeat (20) send_item(essr_pkg::ModeDown, 16'($urandom), 16'($urandom));
    send_item(essr_pkg::ModeRelease, 16'($urandom), 16'($urandom));
  endtask

  // Bursts of ticks, key holds with releases, and some noise items.
  task automatic run_traffic(input int quota);
    int first, n, kind;
    logic [2:0] key;
    first = beats_in;
    while (beats_in - first < quota) begin
      steady = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        n = $urandom_range(1, 8);
        repeat (n) send_item(essr_pkg::ModeTick, pick_period(), pick_current());
      end else if (kind < 8) begin
        key = $urandom_range(0, 1) ? essr_pkg::ModeUp : essr_pkg::ModeDown;
        n = $urandom_range(1, 24);
        repeat (n) send_item(key, 16'($urandom), 16'($urandom));
        if ($urandom_range(0, 3) != 0) begin
          send_item(essr_pkg::ModeRelease, 16'($urandom), 16'($urandom));
        end
      end else if ($urandom_range(0, 1)) begin
        send_item(essr_pkg::ModeOff, 16'($urandom), 16'($urandom));
      end else begin
        send_item(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  // Fixed corners of the register space, then random settings.
  task automatic test_settings();
    regulator_cfg_t c;
    c = '{12'd0, 12'd4095, 10'd1000, 10'd0, 8'd1, 8'd255, 16'hFFFF};
    program_regulator(c);
    run_traffic(30);
    // small limit: the coarse up step can never be taken; zero slots skip speed
    c = '{12'd7, 12'd0, 10'd0, 10'd1000, 8'd255, 8'd0, 16'd0};
    program_regulator(c);
    run_traffic(30);
    // narrow window high up: coarse steps run into both limits
    c = '{12'd3000, 12'd2990, 10'd5, 10'd900, 8'd200, 8'd3, 16'd1000};
    program_regulator(c);
    run_traffic(30);
    repeat (4) begin
      program_regulator(random_cfg());
      run_traffic(30);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: accept result beats under random stalls and check them
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid_o && out_ready) begin
        got = '{pwm_compare_o, duty_now_o, measured_speed_o, target_speed_o, running_o};
        results_seen++;
        if (regulator_reports.size() == 0) begin
          flag_failure($sformatf("result beat with nothing owed: pwm=%0d duty=%0d",
                                 got.pwm, got.duty));
        end else begin
          want = regulator_reports.pop_front();
          if (got !== want)
            flag_failure($sformatf({"report %0d mismatch: expected pwm=%0d duty=%0d ",
              "speed=%0d target=%0d run=%0b, got pwm=%0d duty=%0d speed=%0d ",
              "target=%0d run=%0b"}, results_seen, want.pwm, want.duty, want.speed,
              want.target, want.running, got.pwm, got.duty, got.speed, got.target,
              got.running));
        end
        out_hold = steady ? 0 : $urandom_range(0, MaxGap);
      end
      // stall counts down only while a result is waiting
      if (out_hold > 0) begin
        out_ready <= 1'b0;
        if (out_valid_o) out_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready_o) || (out_valid_o && out_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= Watchdog) begin
      $display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
      $display("** encoder_speed_step_regulator_core: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_items();
    test_hold_ramp();
    program_regulator('{12'd4095, 12'd0, 10'd0, 10'd1000, 8'd255, 8'd1, 16'd0});
    test_long_hold();
    run_traffic(30);
    test_settings();

    // drain, then give a late stray result time to show up
    settle();
    repeat (DrainWait) @(posedge clk);
    if (regulator_reports.size() != 0) begin
      $display("ERROR: %0d reports never arrived", regulator_reports.size());
      failures += regulator_reports.size();
    end

    $display("Sent %0d items and checked %0d reports over %0d register settings,",
             beats_in, results_seen, cfg_phases + 1);
    $display("including hold-counter saturation and every item mode.");
    if (failures == 0) begin
      $display("** encoder_speed_step_regulator_core: PASSED **");
    end else begin
      $display("%0d failures", failures);
      $display("** encoder_speed_step_regulator_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/essr_pkg.sv
design/essr_div.sv
design/essr_setpt.sv
design/encoder_speed_step_regulator_core.sv
design/essr_checker.sv
tb/testbench.sv
